@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DLTQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be true outside reset.
`define DLTQ_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DLTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DLTQ_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ hw/rtl/dltq_pkg.sv @@
// Shared types and constants of the delta-list timer queue.
// Depends on nothing; used by dltq_front, dltq_back and the top level.
package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DELAY_BITS  = 32;
    localparam int ID_BITS     = 4;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_IDS     = 1 << ID_BITS;

    // Request codes on the command port
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ARM    = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Classified operations passed from front to back
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ARM      = 2'd1;
    localparam logic [1:0] OP_ARM_ZERO = 2'd2;
    localparam logic [1:0] OP_CANCEL   = 2'd3;

    // Result codes
    localparam logic [2:0] RES_IDLE        = 3'd0;
    localparam logic [2:0] RES_EXPIRED     = 3'd1;
    localparam logic [2:0] RES_ARMED       = 3'd2;
    localparam logic [2:0] RES_CANCELLED   = 3'd3;
    localparam logic [2:0] RES_FULL        = 3'd4;
    localparam logic [2:0] RES_ZERO_DELAY  = 3'd5;
    localparam logic [2:0] RES_ALREADY     = 3'd6;
    localparam logic [2:0] RES_NOT_PENDING = 3'd7;

    typedef logic [DELAY_BITS-1:0] delta_t;
    typedef logic [ID_BITS-1:0]    tid_t;

    typedef struct packed {
        logic [1:0] op;
        tid_t       id;
        delta_t     delay;
    } cmd_t;

    // Command beat from the front queue to the back engine
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

@@ hw/rtl/dltq_front.sv @@
// Front part: takes requests from the command port, classifies them and queues them as command beats.
// Depends on dltq_pkg.
module dltq_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          req_type,
    input  logic [3:0]          timer_id,
    input  logic [31:0]         delay,
    output logic                busy,
    output dltq_pkg::cmd_beat_t beat,
    input  logic                pop
);

    dltq_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           accept;
    logic           push;
    dltq_pkg::cmd_t cls;

    assign busy   = (count_reg == 2'd2);
    assign accept = start && !busy;
    assign push   = accept && (req_type != dltq_pkg::REQ_NONE);

    // Classify the request
    always_comb
    begin
        cls.id    = timer_id;
        cls.delay = dltq_pkg::delta_t'(delay);
        unique case (req_type)
            dltq_pkg::REQ_TICK:   cls.op = dltq_pkg::OP_TICK;
            dltq_pkg::REQ_ARM:    cls.op = (cls.delay == '0) ? dltq_pkg::OP_ARM_ZERO
                                                             : dltq_pkg::OP_ARM;
            dltq_pkg::REQ_CANCEL: cls.op = dltq_pkg::OP_CANCEL;
            default:              cls.op = dltq_pkg::OP_TICK;
        endcase
    end

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    assign beat.valid = (count_reg != 2'd0);
    assign beat.cmd   = mem_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/dltq_back.sv @@
// Back part: keeps the sorted delta list and produces the result beats.
// Depends on dltq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dltq_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  dltq_pkg::cmd_beat_t beat,
    output logic                pop,
    output logic                done,
    output logic [2:0]          event_res,
    output logic [3:0]          event_timer,
    output logic [31:0]         head_remaining,
    output logic                is_last
);

    localparam int QD = dltq_pkg::QUEUE_DEPTH;
    localparam int OB = dltq_pkg::OCC_BITS;
    localparam int IB = dltq_pkg::IDX_BITS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COUNT   = 3'd1;
    localparam logic [2:0] ST_EXPIRE  = 3'd2;
    localparam logic [2:0] ST_WALK    = 3'd3;
    localparam logic [2:0] ST_INSERT  = 3'd4;
    localparam logic [2:0] ST_FIND    = 3'd5;
    localparam logic [2:0] ST_CADD    = 3'd6;
    localparam logic [2:0] ST_CSHIFT  = 3'd7;

    dltq_pkg::tid_t   timer_reg [QD];
    dltq_pkg::delta_t delta_reg [QD];
    dltq_pkg::tid_t   timer_next [QD];
    dltq_pkg::delta_t delta_next [QD];

    logic [2:0]                      state_reg, state_next;
    logic [OB-1:0]                   occ_reg, occ_next;
    logic [dltq_pkg::NUM_IDS-1:0]    pend_reg, pend_next;
    logic [OB-1:0]                   idx_reg, idx_next;
    logic [OB-1:0]                   cnt_reg, cnt_next;
    dltq_pkg::delta_t                rem_reg, rem_next;
    dltq_pkg::delta_t                head_reg, head_next;
    dltq_pkg::tid_t                  id_reg, id_next;

    logic                            done_reg, done_next;
    logic [2:0]                      res_reg, res_next;
    dltq_pkg::tid_t                  evt_reg, evt_next;
    dltq_pkg::delta_t                hout_reg, hout_next;
    logic                            last_reg, last_next;

    // List edit controls
    logic                            ins_en;
    logic                            rm_en;
    logic [OB-1:0]                   rm_pos;
    logic                            rm_set;
    logic                            wr0_en;
    dltq_pkg::delta_t                wr0_val;

    dltq_pkg::delta_t                rd_delta;
    dltq_pkg::tid_t                  rd_timer;
    dltq_pkg::delta_t                cur_head;
    dltq_pkg::delta_t                dec;
    logic                            idx_in;

    assign rd_delta = delta_reg[idx_reg[IB-1:0]];
    assign rd_timer = timer_reg[idx_reg[IB-1:0]];
    assign idx_in   = (idx_reg < occ_reg);
    assign cur_head = (occ_reg != '0) ? delta_reg[0] : '0;
    assign dec      = delta_reg[0] - dltq_pkg::delta_t'(delta_reg[0] != '0);

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        pend_next  = pend_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        head_next  = head_reg;
        id_next    = id_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        evt_next   = evt_reg;
        hout_next  = hout_reg;
        last_next  = 1'b0;
        ins_en     = 1'b0;
        rm_en      = 1'b0;
        rm_pos     = '0;
        rm_set     = 1'b0;
        wr0_en     = 1'b0;
        wr0_val    = dec;
        pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (beat.valid)
                begin
                    pop       = 1'b1;
                    id_next   = beat.cmd.id;
                    evt_next  = beat.cmd.id;
                    hout_next = cur_head;
                    last_next = 1'b1;
                    unique case (beat.cmd.op)
                        dltq_pkg::OP_TICK:
                        begin
                            if (occ_reg == '0)
                            begin
                                done_next = 1'b1;
                                res_next  = dltq_pkg::RES_IDLE;
                                evt_next  = '0;
                            end
                            else if (dec != '0)
                            begin
                                wr0_en    = 1'b1;
                                done_next = 1'b1;
                                res_next  = dltq_pkg::RES_IDLE;
                                evt_next  = timer_reg[0];
                                hout_next = dec;
                            end
                            else
                            begin
                                wr0_en     = 1'b1;
                                last_next  = 1'b0;
                                idx_next   = OB'(1);
                                state_next = ST_COUNT;
                            end
                        end
                        dltq_pkg::OP_ARM_ZERO:
                        begin
                            done_next = 1'b1;
                            res_next  = dltq_pkg::RES_ZERO_DELAY;
                        end
                        dltq_pkg::OP_ARM:
                        begin
                            if (pend_reg[beat.cmd.id])
                            begin
                                done_next = 1'b1;
                                res_next  = dltq_pkg::RES_ALREADY;
                            end
                            else if (occ_reg >= OB'(QD))
                            begin
                                done_next = 1'b1;
                                res_next  = dltq_pkg::RES_FULL;
                            end
                            else
                            begin
                                last_next  = 1'b0;
                                idx_next   = '0;
                                rem_next   = beat.cmd.delay;
                                state_next = ST_WALK;
                            end
                        end
                        dltq_pkg::OP_CANCEL:
                        begin
                            if (!pend_reg[beat.cmd.id])
                            begin
                                done_next = 1'b1;
                                res_next  = dltq_pkg::RES_NOT_PENDING;
                            end
                            else
                            begin
                                last_next  = 1'b0;
                                idx_next   = '0;
                                state_next = ST_FIND;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            // Count the run of zero deltas behind the expiring head
            ST_COUNT:
            begin
                if (idx_in && rd_delta == '0)
                begin
                    idx_next = idx_reg + OB'(1);
                end
                else
                begin
                    head_next  = idx_in ? rd_delta : '0;
                    cnt_next   = idx_reg;
                    state_next = ST_EXPIRE;
                end
            end
            // One expired timer per cycle, head removed each time
            ST_EXPIRE:
            begin
                done_next = 1'b1;
                res_next  = dltq_pkg::RES_EXPIRED;
                evt_next  = timer_reg[0];
                hout_next = head_reg;
                last_next = (cnt_reg == OB'(1));
                pend_next[timer_reg[0]] = 1'b0;
                rm_en     = 1'b1;
                rm_pos    = '0;
                occ_next  = occ_reg - OB'(1);
                cnt_next  = cnt_reg - OB'(1);
                if (cnt_reg == OB'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            // Walk past entries that fire no later than the new timer
            ST_WALK:
            begin
                if (idx_in && rd_delta <= rem_reg)
                begin
                    rem_next = rem_reg - rd_delta;
                    idx_next = idx_reg + OB'(1);
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                ins_en     = 1'b1;
                occ_next   = occ_reg + OB'(1);
                pend_next[id_reg] = 1'b1;
                done_next  = 1'b1;
                res_next   = dltq_pkg::RES_ARMED;
                evt_next   = id_reg;
                hout_next  = (idx_reg == '0) ? rem_reg : delta_reg[0];
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                if (!idx_in)
                begin
                    pend_next[id_reg] = 1'b0;
                    done_next  = 1'b1;
                    res_next   = dltq_pkg::RES_CANCELLED;
                    evt_next   = id_reg;
                    hout_next  = cur_head;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (rd_timer == id_reg)
                begin
                    rem_next   = rd_delta;
                    idx_next   = idx_reg + OB'(1);
                    state_next = ST_CADD;
                end
                else
                begin
                    idx_next = idx_reg + OB'(1);
                end
            end
            // Fold the cancelled delta into its successor
            ST_CADD:
            begin
                rem_next   = rd_delta + rem_reg;
                idx_next   = idx_reg - OB'(1);
                state_next = ST_CSHIFT;
            end
            ST_CSHIFT:
            begin
                rm_en      = 1'b1;
                rm_pos     = idx_reg;
                rm_set     = (idx_reg + OB'(1) < occ_reg);
                occ_next   = occ_reg - OB'(1);
                pend_next[id_reg] = 1'b0;
                done_next  = 1'b1;
                res_next   = dltq_pkg::RES_CANCELLED;
                evt_next   = id_reg;
                if (occ_reg == OB'(1))
                begin
                    hout_next = '0;
                end
                else
                begin
                    hout_next = (idx_reg == '0) ? rem_reg : delta_reg[0];
                end
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-entry list update: insert shifts up, remove shifts down, a tick rewrites entry 0
    always_comb
    begin
        for (int j = 0; j < QD; j++)
        begin
            timer_next[j] = timer_reg[j];
            delta_next[j] = delta_reg[j];
            if (ins_en)
            begin
                if (OB'(j) > idx_reg)
                begin
                    timer_next[j] = timer_reg[(j + QD - 1) % QD];
                    delta_next[j] = delta_reg[(j + QD - 1) % QD];
                end
                if (OB'(j) == idx_reg)
                begin
                    timer_next[j] = id_reg;
                    delta_next[j] = rem_reg;
                end
                if (OB'(j) == idx_reg + OB'(1) && idx_in)
                begin
                    delta_next[j] = rd_delta - rem_reg;
                end
            end
            if (rm_en)
            begin
                if (OB'(j) >= rm_pos && j < QD - 1)
                begin
                    timer_next[j] = timer_reg[(j + 1) % QD];
                    delta_next[j] = delta_reg[(j + 1) % QD];
                end
                if (OB'(j) == rm_pos && rm_set)
                begin
                    delta_next[j] = rem_reg;
                end
            end
            if (wr0_en && j == 0)
            begin
                delta_next[j] = wr0_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QD; j++)
        begin
            timer_reg[j] <= timer_next[j];
            delta_reg[j] <= delta_next[j];
        end
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        head_reg <= head_next;
        id_reg   <= id_next;
        res_reg  <= res_next;
        evt_reg  <= evt_next;
        hout_reg <= hout_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            pend_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    assign done           = done_reg;
    assign event_res      = res_reg;
    assign event_timer    = evt_reg;
    assign head_remaining = 32'(hout_reg);
    assign is_last        = done_reg && last_reg;

    `DLTQ_NEVER(a_occ_range, clk, rst_n, occ_reg > OB'(QD), "occupancy beyond depth")
    `DLTQ_ASSERT(a_pend_count, clk, rst_n,
        (state_reg == ST_IDLE) |-> ($countones(pend_reg) == 32'(occ_reg)),
        "pending mask disagrees with occupancy")
    `DLTQ_ASSERT(a_pop_idle, clk, rst_n, pop |-> (state_reg == ST_IDLE), "command taken while busy")
    `DLTQ_NEVER(a_expire_empty, clk, rst_n, (state_reg == ST_EXPIRE) && (occ_reg == '0),
        "expiry on empty list")

endmodule

@@ hw/rtl/delta_list_timer_queue_core.sv @@
// Top level of the delta-list timer queue.
// Depends on dltq_pkg, dltq_front and dltq_back.
//
// Command port: a beat is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Every tick, arm or cancel gives one or
// more result beats, each shown for one cycle with done high; the receiver cannot
// stall them, and is_last marks the final beat of a command. Request code 3 gives
// no result. The list engine takes a command off the queue only while idle. It
// answers a rejected request or a tick that expires nothing straight from the idle
// state; an arm walks past the entries that fire no later than it (up to 15, as a
// full list rejects the arm) and then inserts; a cancel searches for the timer,
// folds its delta into its successor and removes it; a tick that expires n timers
// scans the run of zero deltas and then hands out one expiry per cycle. A command
// is registered in the command queue before the engine can take it. The list
// registers have a single read port, so the engine walks them one entry at a time.
module delta_list_timer_queue_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  timer_id,
    input  logic [31:0] delay,
    output logic        done,
    output logic [2:0]  event_res,
    output logic [3:0]  event_timer,
    output logic [31:0] head_remaining,
    output logic        is_last
);

    dltq_pkg::cmd_beat_t beat;
    logic                pop;

    dltq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .timer_id (timer_id),
        .delay    (delay),
        .busy     (busy),
        .beat     (beat),
        .pop      (pop)
    );

    dltq_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat           (beat),
        .pop            (pop),
        .done           (done),
        .event_res      (event_res),
        .event_timer    (event_timer),
        .head_remaining (head_remaining),
        .is_last        (is_last)
    );

endmodule
